[sv/b64e_pkg.sv]
// Shared types and the character table of the base64 stream encoder.
// No dependencies; used by the front end, group queue, back end and checker.
package b64e_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 24;   // one 3-byte group
  localparam int unsigned SextetW   = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] PadChar = 8'h3D;   // '='

  // Character slot within an output group
  typedef enum logic [1:0] {
    SLOT_0 = 2'd0,
    SLOT_1 = 2'd1,
    SLOT_2 = 2'd2,
    SLOT_3 = 2'd3
  } slot_e;

  // Byte count of a group
  localparam logic [1:0] CntOne   = 2'd1;
  localparam logic [1:0] CntTwo   = 2'd2;
  localparam logic [1:0] CntThree = 2'd3;

  // One classified group handed from front to back
  typedef struct packed {
    logic [WordW-1:0] word;    // first byte in 23:16, zero filled
    logic [1:0]       nbytes;  // 1..3 bytes present
    logic             last;    // group ends the message
  } group_t;

  // Map a 6-bit index to its ASCII character (standard alphabet)
  function automatic logic [7:0] sextet_to_char(input logic [SextetW-1:0] v);
    logic [7:0] ch;
    if (v < 6'd26) begin
      ch = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      ch = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      ch = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      ch = 8'h2B;   // '+'
    end else begin
      ch = 8'h2F;   // '/'
    end
    return ch;
  endfunction

  // True for any character the encoder can produce
  function automatic logic is_b64_char(input logic [7:0] ch);
    return ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A)) ||
           ((ch >= 8'h30) && (ch <= 8'h39)) || (ch == 8'h2B) || (ch == 8'h2F) ||
           (ch == PadChar);
  endfunction

endpackage

[sv/b64e_front.sv]
// Front end of the base64 encoder: gathers input bytes into 3-byte groups.
// Depends on b64e_pkg; pushes finished groups into b64e_queue.
module b64e_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,    // input word accepted
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  output logic                push_o,
  output b64e_pkg::group_t    push_group_o
);

  logic [15:0] held_q, held_d;
  logic [1:0]  pos_q, pos_d;
  logic [1:0]  pos_eff;
  logic [1:0]  count;
  logic        complete;
  logic [23:0] word;

  // An unused position code counts as an empty group
  assign pos_eff  = (pos_q == 2'd3) ? 2'd0 : pos_q;
  assign count    = pos_eff + 2'd1;
  assign complete = (count == b64e_pkg::CntThree) || in_last_i;

  // Place the new byte behind the held ones
  always_comb begin
    word = 24'd0;
    case (pos_eff)
      2'd0:    word = {in_byte_i, 16'd0};
      2'd1:    word = {held_q[15:8], in_byte_i, 8'd0};
      2'd2:    word = {held_q, in_byte_i};
      default: word = 24'd0;
    endcase
  end

  // Holding register and position update
  always_comb begin
    held_d = held_q;
    pos_d  = pos_q;
    if (in_fire_i) begin
      if (complete) begin
        held_d = 16'd0;
        pos_d  = 2'd0;
      end else begin
        held_d = word[23:8];
        pos_d  = count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 16'd0;
      pos_q  <= 2'd0;
    end else begin
      held_q <= held_d;
      pos_q  <= pos_d;
    end
  end

  assign push_o              = in_fire_i && complete;
  assign push_group_o.word   = word;
  assign push_group_o.nbytes = count;
  assign push_group_o.last   = in_last_i;

endmodule

[sv/b64e_queue.sv]
// Short group queue between the encoder front and back ends.
// Depends on b64e_pkg for the group type.
module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepth   // power of two, at least 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64e_pkg::group_t push_group_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output b64e_pkg::group_t pop_group_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64e_pkg::group_t  slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign valid_o     = (cnt_q != '0);
  assign pop_group_o = slots_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_group_i;
    end
  end

endmodule

[sv/b64e_back.sv]
// Back end of the base64 encoder: turns one group into four characters.
// Depends on b64e_pkg; pulls groups from b64e_queue, drives the output register.
module b64e_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  b64e_pkg::group_t q_group_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             out_last_o
);

  b64e_pkg::group_t cur_q, cur_d;
  logic             busy_q, busy_d;
  b64e_pkg::slot_e  slot_q, slot_d;
  logic             ovalid_q, ovalid_d;
  logic [7:0]       ochar_q, ochar_d;
  logic             olast_q, olast_d;
  logic             advance;
  logic             last_slot;
  logic [7:0]       ch;

  assign advance   = busy_q && (!ovalid_q || out_ready_i);
  assign last_slot = (slot_q == b64e_pkg::SLOT_3);
  assign q_pop_o   = q_valid_i && (!busy_q || (advance && last_slot));

  // Character for the current slot, with '=' for missing sextets
  always_comb begin
    ch = b64e_pkg::PadChar;
    case (slot_q)
      b64e_pkg::SLOT_0: ch = b64e_pkg::sextet_to_char(cur_q.word[23:18]);
      b64e_pkg::SLOT_1: ch = b64e_pkg::sextet_to_char(cur_q.word[17:12]);
      b64e_pkg::SLOT_2: ch = (cur_q.nbytes != b64e_pkg::CntOne) ?
                             b64e_pkg::sextet_to_char(cur_q.word[11:6]) : b64e_pkg::PadChar;
      b64e_pkg::SLOT_3: ch = (cur_q.nbytes == b64e_pkg::CntThree) ?
                             b64e_pkg::sextet_to_char(cur_q.word[5:0]) : b64e_pkg::PadChar;
      default:          ch = b64e_pkg::PadChar;
    endcase
  end

  // Group sequencing and output register
  always_comb begin
    cur_d    = cur_q;
    busy_d   = busy_q;
    slot_d   = slot_q;
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;

    if (advance) begin
      ovalid_d = 1'b1;
      ochar_d  = ch;
      olast_d  = cur_q.last && last_slot;
      if (last_slot) begin
        busy_d = q_valid_i;
        slot_d = b64e_pkg::SLOT_0;
      end else begin
        slot_d = b64e_pkg::slot_e'(slot_q + 2'd1);
      end
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end

    if (q_pop_o) begin
      cur_d  = q_group_i;
      busy_d = 1'b1;
      slot_d = b64e_pkg::SLOT_0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      slot_q   <= b64e_pkg::SLOT_0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      slot_q   <= slot_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

endmodule

[sv/base64_stream_encoder.sv]
// Top level of the streaming base64 encoder (standard alphabet, '=' padding).
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Bytes come in on s_axis with tlast on the final byte of a message; characters go out on
// m_axis with tlast on the final character. A byte is taken whenever the group queue has
// room; every third byte, or a final byte, closes a group that the back end turns into four
// characters, one per cycle from its output register while m_axis_tready is high, so the
// output side sets the sustained input rate. The first character of a group passes through
// the queue, the back end's group register and its output register, and the queue holds
// QueueDepth closed groups.
module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
  input  logic       s_axis_tlast,    // is_final_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [7:0] out_char
  output logic       m_axis_tlast     // is_final_char
);

  logic             in_fire;
  logic             push;
  b64e_pkg::group_t push_group;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  b64e_pkg::group_t q_group;

  // Accept a byte whenever a closed group would have room
  assign s_axis_tready = !q_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .push_o       (push),
    .push_group_o (push_group)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_group_o  (q_group)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_group_i   (q_group),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

[sv/b64e_checker.sv]
// Port-level checker for the base64 stream encoder, bound to the top level.
// Depends on b64e_pkg; watches only the top-level ports.
module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic       out_fire;
  logic [1:0] opos_q, opos_d;
  logic       pad_q, pad_d;

  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Character position within the current output group
  always_comb begin
    opos_d = opos_q;
    pad_d  = pad_q;
    if (out_fire) begin
      opos_d = opos_q + 2'd1;
      pad_d  = (m_axis_tdata == b64e_pkg::PadChar);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opos_q <= 2'd0;
      pad_q  <= 1'b0;
    end else begin
      opos_q <= opos_d;
      pad_q  <= pad_d;
    end
  end

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // Only alphabet characters or padding leave the block
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> b64e_pkg::is_b64_char(m_axis_tdata))
    else $error("character outside the base64 set");

  // Message end falls on the fourth character of a group
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && m_axis_tlast |-> opos_q == 2'd3)
    else $error("tlast not on fourth character");

  // Padding never in the first two slots, and a padded third slot pads the fourth and ends the message
  a_pad_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (m_axis_tdata == b64e_pkg::PadChar) |-> (opos_q == 2'd2) || (opos_q == 2'd3))
    else $error("padding in a leading slot");

  a_pad_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (opos_q == 2'd3) && pad_q |->
      (m_axis_tdata == b64e_pkg::PadChar) && m_axis_tlast)
    else $error("broken padding at group end");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[dv/b64e_checker.sv]
// Checker for the base64 stream encoder: watches both stream channels, predicts
// the characters each accepted byte causes, and compares them in order.
// Depends on b64e_pkg (pad character).
module b64e_scoreboard (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,    // [7:0] in_byte
  input  logic       s_tlast_i,    // is_final_byte
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,    // [7:0] out_char
  input  logic       m_tlast_i,    // is_final_char
  output int         fail_cnt_o,
  output int         pending_o
);

  // Standard alphabet, index 0 in the top byte
  localparam logic [8*64-1:0] B64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } b64_char_t;

  b64_char_t  exp_chars[$];
  logic [15:0] held;      // earlier bytes of the open group, first in 15:8
  logic [1:0]  grp_pos;   // bytes held so far
  int          errs;

  function automatic logic [7:0] alpha_char(input logic [5:0] idx);
    return B64Alphabet[8*(63-int'(idx)) +: 8];
  endfunction

  // Gather a byte into the open group; a full group or a final byte closes it
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [1:0]  pos;
    int          cnt;
    logic [23:0] grp;
    b64_char_t   c;
    pos = (grp_pos == 2'd3) ? 2'd0 : grp_pos;
    if (pos == 2'd0) held = '0;
    cnt = int'(pos) + 1;
    if (cnt < 3 && !fin) begin
      held = held | (16'(b) << (8 * (1 - int'(pos))));
      grp_pos = 2'(cnt);
    end else begin
      grp = {held, 8'h00} | (24'(b) << (8 * (2 - int'(pos))));
      for (int k = 0; k < 4; k++) begin
        // sextets past the bytes present become padding
        if ((k == 2 && cnt < 2) || (k == 3 && cnt < 3)) begin
          c.ch = b64e_pkg::PadChar;
        end else begin
          c.ch = alpha_char(grp[18-6*k +: 6]);
        end
        c.fin = fin && (k == 3);
        exp_chars.push_back(c);
      end
      held = '0;
      grp_pos = 2'd0;
    end
  endtask

  // Compare one output word with the oldest expected character
  task automatic check_char(input logic [7:0] ch, input logic fin);
    b64_char_t c;
    if (exp_chars.size() == 0) begin
      $error("unexpected character: out_char %h is_final_char %b", ch, fin);
      errs++;
    end else begin
      c = exp_chars.pop_front();
      if (ch !== c.ch) begin
        $error("out_char mismatch: expected %h, actual %h", c.ch, ch);
        errs++;
      end
      if (fin !== c.fin) begin
        $error("is_final_char mismatch: expected %b, actual %b", c.fin, fin);
        errs++;
      end
    end
  endtask

  // Sample both channels at the edge; the counts seen by the top are registered
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = '0;
      grp_pos = '0;
      errs = 0;
      exp_chars.delete();
      fail_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_char(m_tdata_i, m_tlast_i);
      if (s_tvalid_i && s_tready_i) encode_byte(s_tdata_i, s_tlast_i);
      fail_cnt_o <= errs;
      pending_o <= exp_chars.size();
    end
  end

endmodule

[dv/tb_top.sv]
// Testbench top for the base64 stream encoder: clock, reset, byte stimulus,
// random stalls on the character side and the final verdict.
// Depends on base64_stream_encoder and b64e_scoreboard.
module tb_top;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;    // [7:0] in_byte
  logic       s_axis_tlast;    // is_final_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;    // [7:0] out_char
  logic       m_axis_tlast;    // is_final_char

  int   fail_cnt;
  int   pending;
  logic calm;          // no new idle gaps on either side while set
  int   rx_stall;
  int   n_sent;

  base64_stream_encoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  b64e_scoreboard i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_i(s_axis_tready),
    .s_tdata_i (s_axis_tdata),
    .s_tlast_i (s_axis_tlast),
    .m_tvalid_i(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .m_tdata_i (m_axis_tdata),
    .m_tlast_i (m_axis_tlast),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Character side backpressure
  always @(posedge clk_i) begin
    if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (calm || $urandom_range(0, 99) < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      rx_stall <= pick_gap() - 1;
    end
  end

  // Offer one byte, after an optional idle gap, and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 35) gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // Hold off the sender until every expected character has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    logic [8:0] directed[$];
    int         msg_len;
    int         r;
    int         n_msg;
    logic [7:0] b;

    // {final, byte}: one-, two- and three-byte messages, '+' and '/', full groups
    // followed by a short final group, and all-zero and all-one bytes
    directed = '{
      {1'b1, 8'h00},
      {1'b0, 8'hFF}, {1'b1, 8'hFF},
      {1'b0, 8'hFB}, {1'b0, 8'hEF}, {1'b1, 8'hBE},
      {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'h00},
      {1'b0, 8'h10}, {1'b0, 8'h83}, {1'b1, 8'h41},
      {1'b0, 8'h4D}, {1'b0, 8'h61}, {1'b0, 8'h6E}, {1'b0, 8'h4D}, {1'b1, 8'h61}
    };

    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tlast <= 1'b0;
    m_axis_tready <= 1'b0;
    calm <= 1'b0;
    rx_stall = 0;
    n_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    drain();

    // Random messages, mostly short, some long
    n_msg = 0;
    while (n_sent < 354) begin
      r = $urandom_range(0, 99);
      if (r < 70) msg_len = $urandom_range(1, 6);
      else if (r < 95) msg_len = $urandom_range(7, 15);
      else msg_len = $urandom_range(16, 40);
      calm <= ($urandom_range(0, 4) == 0);
      for (int k = 0; k < msg_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 10) b = 8'h00;
        else if (r < 20) b = 8'hFF;
        else b = 8'($urandom());
        send_byte(b, k == msg_len - 1);
      end
      n_msg++;
      if (n_msg == 10 || $urandom_range(0, 11) == 0) drain();
    end

    calm <= 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
